// ===== hw/rtl/lpcc_pkg.sv =====
// Shared types, codes and helper functions for the long-press countdown controller.
`default_nettype none
package lpcc_pkg;

  typedef enum logic [1:0] {
    OP_BUTTON = 2'd0,
    OP_TICK   = 2'd1,
    OP_SERIAL = 2'd2,
    OP_POT    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_PRESS     = 3'd1,
    EV_LONG      = 3'd2,
    EV_SHORT_REL = 3'd3,
    EV_LONG_REL  = 3'd4
  } bevent_t;

  // config register indexes
  localparam logic [1:0] REG_LONG_PRESS = 2'd0;
  localparam logic [1:0] REG_SAMPLE_IVL = 2'd1;
  localparam logic [1:0] REG_TICK_STEP  = 2'd2;

  localparam logic [15:0] LONG_PRESS_RST = 16'd700;
  localparam logic [15:0] SAMPLE_IVL_RST = 16'd50;
  localparam logic [6:0]  TICK_STEP_RST  = 7'd5;
  localparam logic [6:0]  RELOAD_RST     = 7'd30;

  localparam logic [7:0] CHAR_ONE  = 8'h31;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [12:0] POT_FULL = 13'd1023;

  typedef struct packed {
    op_t         op;
    logic [31:0] time_ms;
    logic        button_level;
    logic [7:0]  serial_byte;
    logic [9:0]  pot_value;
  } item_t;

  typedef struct packed {
    logic [3:0] display_digit;
    logic [6:0] count_now;
    logic [6:0] reload_now;
    logic       in_config;
    logic       feed_due;
    bevent_t    button_event;
  } result_t;

  typedef struct packed {
    logic [15:0] long_press_ms;
    logic [15:0] sample_interval_ms;
    logic [6:0]  tick_step;
  } cfg_t;

  // ((1023 - pot) * 8 / 1023 + 1) * 10, as eight parallel threshold compares
  function automatic logic [6:0] pot_select(input logic [9:0] pot);
    logic [12:0] scaled;
    logic [3:0]  q;
    scaled = {~pot, 3'b000};
    q = 4'd0;
    for (int k = 1; k <= 8; k++) begin
      if (scaled >= 13'(POT_FULL * 13'(k))) begin
        q = q + 4'd1;
      end
    end
    return 7'(q + 4'd1) * 7'd10;
  endfunction

  // v / 10 for v below 128 via reciprocal multiply
  function automatic logic [3:0] div10(input logic [6:0] v);
    logic [14:0] prod;
    prod = 15'(v) * 15'd205;
    return prod[14:11];
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/lpcc_in_if.sv =====
// Input event channel: valid/ready plus one event word.
`default_nettype none
interface lpcc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] time_ms;
  logic        button_level;
  logic [7:0]  serial_byte;
  logic [9:0]  pot_value;

  modport source (output valid, op, time_ms, button_level, serial_byte, pot_value,
                  input ready);
  modport sink (input valid, op, time_ms, button_level, serial_byte, pot_value,
                output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/lpcc_out_if.sv =====
// Result channel: valid/ready plus one result word.
`default_nettype none
interface lpcc_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] display_digit;
  logic [6:0] count_now;
  logic [6:0] reload_now;
  logic       in_config;
  logic       feed_due;
  logic [2:0] button_event;

  modport source (output valid, display_digit, count_now, reload_now, in_config,
                  feed_due, button_event, input ready);
  modport sink (input valid, display_digit, count_now, reload_now, in_config,
                feed_due, button_event, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/lpcc_cfg_if.sv =====
// Configuration write channel: valid/ready, register index and write data.
`default_nettype none
interface lpcc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/lpcc_core.sv =====
// Controller state and the single-pass update for one event word.
`default_nettype none
module lpcc_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             fire,
  input  wire lpcc_pkg::item_t  item,
  input  wire lpcc_pkg::cfg_t   cfg,
  output lpcc_pkg::result_t     res
);

  logic [6:0]  countdown_r, countdown_nxt;
  logic [6:0]  reload_r, reload_nxt;
  logic [6:0]  selection_r, selection_nxt;
  logic        cfg_active_r, cfg_active_nxt;
  logic        was_high_r, was_high_nxt;
  logic        latched_r, latched_nxt;
  logic [31:0] press_start_r, press_start_nxt;
  logic [31:0] last_sample_r, last_sample_nxt;

  always_comb begin
    logic [31:0] elapsed;
    logic [31:0] dur;
    logic        press;
    logic        feed;
    lpcc_pkg::bevent_t ev;

    countdown_nxt   = countdown_r;
    reload_nxt      = reload_r;
    selection_nxt   = selection_r;
    cfg_active_nxt  = cfg_active_r;
    was_high_nxt    = was_high_r;
    latched_nxt     = latched_r;
    press_start_nxt = press_start_r;
    last_sample_nxt = last_sample_r;
    feed            = 1'b0;
    ev              = lpcc_pkg::EV_NONE;
    elapsed         = item.time_ms - last_sample_r;
    press           = item.button_level && !was_high_r && !latched_r;
    dur             = item.time_ms - (press ? item.time_ms : press_start_r);

    unique case (item.op)
      lpcc_pkg::OP_BUTTON: begin
        // samples no further apart than the interval are dropped
        if (elapsed > {16'd0, cfg.sample_interval_ms}) begin
          if (press) begin
            press_start_nxt = item.time_ms;
            was_high_nxt    = 1'b1;
            ev              = lpcc_pkg::EV_PRESS;
            if (cfg_active_r) begin
              reload_nxt     = selection_r;
              countdown_nxt  = selection_r;
              cfg_active_nxt = 1'b0;
            end
          end
          if (item.button_level && !latched_r && dur >= {16'd0, cfg.long_press_ms}) begin
            latched_nxt    = 1'b1;
            cfg_active_nxt = 1'b1;
            ev             = lpcc_pkg::EV_LONG;
          end
          if (!item.button_level && was_high_r) begin
            was_high_nxt = 1'b0;
            latched_nxt  = 1'b0;
            ev = (dur < {16'd0, cfg.long_press_ms}) ? lpcc_pkg::EV_SHORT_REL
                                                     : lpcc_pkg::EV_LONG_REL;
          end
          last_sample_nxt = item.time_ms;
        end
      end
      lpcc_pkg::OP_TICK: begin
        if (!cfg_active_r) begin
          if (countdown_r <= cfg.tick_step) begin
            countdown_nxt = reload_r;
            feed          = 1'b1;
          end else begin
            countdown_nxt = countdown_r - cfg.tick_step;
          end
        end
      end
      lpcc_pkg::OP_SERIAL: begin
        if (item.serial_byte >= lpcc_pkg::CHAR_ONE && item.serial_byte <= lpcc_pkg::CHAR_NINE) begin
          reload_nxt = 7'(item.serial_byte[3:0]) * 7'd10;
        end
        countdown_nxt = reload_nxt;
      end
      lpcc_pkg::OP_POT: begin
        if (cfg_active_r) begin
          selection_nxt = lpcc_pkg::pot_select(item.pot_value);
        end
      end
    endcase

    res.display_digit = lpcc_pkg::div10(cfg_active_nxt ? selection_nxt : countdown_nxt);
    res.count_now     = countdown_nxt;
    res.reload_now    = reload_nxt;
    res.in_config     = cfg_active_nxt;
    res.feed_due      = feed;
    res.button_event  = ev;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      countdown_r   <= 7'd0;
      reload_r      <= lpcc_pkg::RELOAD_RST;
      selection_r   <= 7'd0;
      cfg_active_r  <= 1'b0;
      was_high_r    <= 1'b0;
      latched_r     <= 1'b0;
      press_start_r <= 32'd0;
      last_sample_r <= 32'd0;
    end else if (fire) begin
      countdown_r   <= countdown_nxt;
      reload_r      <= reload_nxt;
      selection_r   <= selection_nxt;
      cfg_active_r  <= cfg_active_nxt;
      was_high_r    <= was_high_nxt;
      latched_r     <= latched_nxt;
      press_start_r <= press_start_nxt;
      last_sample_r <= last_sample_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/long_press_countdown_controller.sv =====
// Top level: input register, config registers, update core and result register.
// Order: an accepted input word waits in the input register, then its result word
//   in the result register, which holds the flow while the receiver stalls.
// Throughput: one word per cycle while the result side takes words; the core
//   computes each update combinationally from the input register.
// Reset (rst_n low, synchronous): both stages empty, state and config registers
//   to their defaults (long press 700, interval 50, step 5, reload 30).
`default_nettype none
module long_press_countdown_controller (
  input  wire logic  clk,
  input  wire logic  rst_n,
  lpcc_in_if.sink    in_ch,
  lpcc_out_if.source out_ch,
  lpcc_cfg_if.sink   cfg_ch
);

  // config registers; writes must come only while idle: the user is bound, as the block has no hazard guard
  lpcc_pkg::cfg_t cfg_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_press_ms      <= lpcc_pkg::LONG_PRESS_RST;
      cfg_r.sample_interval_ms <= lpcc_pkg::SAMPLE_IVL_RST;
      cfg_r.tick_step          <= lpcc_pkg::TICK_STEP_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        lpcc_pkg::REG_LONG_PRESS: cfg_r.long_press_ms      <= cfg_ch.data;
        lpcc_pkg::REG_SAMPLE_IVL: cfg_r.sample_interval_ms <= cfg_ch.data;
        lpcc_pkg::REG_TICK_STEP:  cfg_r.tick_step          <= cfg_ch.data[6:0];
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // pipeline advance: result slot free or being drained this cycle
  logic in_v_r;
  logic out_v_r;
  logic adv;
  logic fire;
  lpcc_pkg::item_t   item_r;
  lpcc_pkg::result_t res;
  lpcc_pkg::result_t res_r;

  assign adv         = !out_v_r || out_ch.ready;
  assign fire        = in_v_r && adv;
  assign in_ch.ready = !in_v_r || adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      item_r.op           <= lpcc_pkg::op_t'(in_ch.op);
      item_r.time_ms      <= in_ch.time_ms;
      item_r.button_level <= in_ch.button_level;
      item_r.serial_byte  <= in_ch.serial_byte;
      item_r.pot_value    <= in_ch.pot_value;
    end
  end

  lpcc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item_r),
    .cfg   (cfg_r),
    .res   (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.display_digit = res_r.display_digit;
  assign out_ch.count_now     = res_r.count_now;
  assign out_ch.reload_now    = res_r.reload_now;
  assign out_ch.in_config     = res_r.in_config;
  assign out_ch.feed_due      = res_r.feed_due;
  assign out_ch.button_event  = res_r.button_event;

endmodule
`default_nettype wire

// ===== test/lpcc_result_checker.sv =====
// Result checker: predicts every result word of the countdown controller and compares it.
`timescale 1ns / 100ps
module lpcc_result_checker (
  input  logic clk,
  input  logic rst_n,
  lpcc_in_if   in_ch,
  lpcc_out_if  out_ch,
  lpcc_cfg_if  cfg_ch,
  output int   fail_count,
  output int   outstanding
);

  localparam int         REPORT_MAX = 10;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;

  // shadow config registers
  logic [15:0] hold_ms;
  logic [15:0] gap_ms;
  logic [6:0]  step;

  // shadow controller state
  logic [6:0]  count;
  logic [6:0]  reload;
  logic [6:0]  pick;
  logic        cfg_mode;
  logic        held;
  logic        latched;
  logic [31:0] t_press;
  logic [31:0] t_last;

  lpcc_pkg::result_t expected_q[$];
  int                misses = 0;

  task automatic apply_event(input lpcc_pkg::item_t w, output lpcc_pkg::result_t r);
    logic [31:0]       span;
    lpcc_pkg::bevent_t ev;
    logic              feed;
    ev   = lpcc_pkg::EV_NONE;
    feed = 1'b0;
    case (w.op)
      lpcc_pkg::OP_BUTTON: begin
        span = w.time_ms - t_last;
        if (span > 32'(gap_ms)) begin
          if (w.button_level && !held && !latched) begin
            t_press = w.time_ms;
            held    = 1'b1;
            ev      = lpcc_pkg::EV_PRESS;
            if (cfg_mode) begin
              reload   = pick;
              count    = pick;
              cfg_mode = 1'b0;
            end
          end
          span = w.time_ms - t_press;
          if (w.button_level && !latched && span >= 32'(hold_ms)) begin
            latched  = 1'b1;
            cfg_mode = 1'b1;
            ev       = lpcc_pkg::EV_LONG;
          end
          if (!w.button_level && held) begin
            held    = 1'b0;
            latched = 1'b0;
            ev      = (span < 32'(hold_ms)) ? lpcc_pkg::EV_SHORT_REL
                                            : lpcc_pkg::EV_LONG_REL;
          end
          t_last = w.time_ms;
        end
      end
      lpcc_pkg::OP_TICK: begin
        if (!cfg_mode) begin
          if (count <= step) begin
            count = reload;
            feed  = 1'b1;
          end else begin
            count = count - step;
          end
        end
      end
      lpcc_pkg::OP_SERIAL: begin
        if (w.serial_byte >= lpcc_pkg::CHAR_ONE && w.serial_byte <= lpcc_pkg::CHAR_NINE) begin
          reload = 7'(w.serial_byte - CHAR_ZERO) * 7'd10;
        end
        count = reload;
      end
      lpcc_pkg::OP_POT: begin
        if (cfg_mode) begin
          pick = 7'(((1023 - int'(w.pot_value)) * 8 / 1023 + 1) * 10);
        end
      end
    endcase
    r.display_digit = 4'((cfg_mode ? pick : count) / 7'd10);
    r.count_now     = count;
    r.reload_now    = reload;
    r.in_config     = cfg_mode;
    r.feed_due      = feed;
    r.button_event  = ev;
  endtask

  task automatic note_miss(input string what, input lpcc_pkg::result_t want,
                           input lpcc_pkg::result_t got);
    misses++;
    if (misses <= REPORT_MAX) begin
      $display("%0t: %s: expected digit %0d count %0d reload %0d cfg %0b feed %0b event %0d",
               $time, what, want.display_digit, want.count_now, want.reload_now,
               want.in_config, want.feed_due, want.button_event);
      $display("%0t:   got      digit %0d count %0d reload %0d cfg %0b feed %0b event %0d",
               $time, got.display_digit, got.count_now, got.reload_now,
               got.in_config, got.feed_due, got.button_event);
    end
  endtask

  task automatic check_word();
    lpcc_pkg::result_t got;
    lpcc_pkg::result_t want;
    got = {out_ch.display_digit, out_ch.count_now, out_ch.reload_now,
           out_ch.in_config, out_ch.feed_due, out_ch.button_event};
    if (expected_q.size() == 0) begin
      want = '0;
      note_miss("result word with nothing pending", want, got);
    end else begin
      want = expected_q.pop_front();
      if (got.display_digit !== want.display_digit || got.count_now !== want.count_now ||
          got.reload_now !== want.reload_now || got.in_config !== want.in_config ||
          got.feed_due !== want.feed_due || got.button_event !== want.button_event) begin
        note_miss("result word mismatch", want, got);
      end
    end
  endtask

  always @(posedge clk) begin
    lpcc_pkg::item_t   w;
    lpcc_pkg::result_t r;
    if (!rst_n) begin
      hold_ms  = lpcc_pkg::LONG_PRESS_RST;
      gap_ms   = lpcc_pkg::SAMPLE_IVL_RST;
      step     = lpcc_pkg::TICK_STEP_RST;
      count    = '0;
      reload   = lpcc_pkg::RELOAD_RST;
      pick     = '0;
      cfg_mode = 1'b0;
      held     = 1'b0;
      latched  = 1'b0;
      t_press  = '0;
      t_last   = '0;
      expected_q.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          lpcc_pkg::REG_LONG_PRESS: hold_ms = cfg_ch.data;
          lpcc_pkg::REG_SAMPLE_IVL: gap_ms  = cfg_ch.data;
          lpcc_pkg::REG_TICK_STEP:  step    = cfg_ch.data[6:0];
          default: ;
        endcase
      end
      // results lag their input by the input and result registers, so compare before queueing
      if (out_ch.valid && out_ch.ready) begin
        check_word();
      end
      if (in_ch.valid && in_ch.ready) begin
        w.op           = lpcc_pkg::op_t'(in_ch.op);
        w.time_ms      = in_ch.time_ms;
        w.button_level = in_ch.button_level;
        w.serial_byte  = in_ch.serial_byte;
        w.pot_value    = in_ch.pot_value;
        apply_event(w, r);
        expected_q.push_back(r);
      end
    end
    fail_count  <= misses;
    outstanding <= expected_q.size();
  end

endmodule

// ===== test/long_press_countdown_controller_tb.sv =====
// Testbench top: clock, reset, event stimulus, idling and verdict for the countdown controller.
`timescale 1ns / 100ps
module long_press_countdown_controller_tb;

  localparam int IDLE_LIMIT  = 5000;  // cycles with no word moving on any channel
  localparam int LONG_HOLD   = 300;   // receiver hold-off, long enough to back up the input
  localparam int PHASE_WORDS = 320;
  localparam int NUM_PHASES  = 6;

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count;
  int   outstanding;

  lpcc_in_if  in_ch();
  lpcc_out_if out_ch();
  lpcc_cfg_if cfg_ch();

  long_press_countdown_controller dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  lpcc_result_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_ch      (cfg_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Stimulus-side view of time and config; used only to shape timestamps so
  // that holds actually cross the long-press threshold under each setting.
  // ---------------------------------------------------------------------------
  logic [31:0] now_ms;
  logic [15:0] cur_hold;
  logic [15:0] cur_gap;
  int          words_sent;
  bit          no_gaps;

  // Offer one input word after a random gap; valid stays up after acceptance so
  // a back-to-back word never lowers and raises it in the same step.
  task automatic send_word(input lpcc_pkg::op_t op, input logic level, input logic [7:0] chr,
                           input logic [9:0] pot, input logic [31:0] stamp);
    int gap;
    // alternate stretches of back-to-back words with stretches of random gaps
    if (words_sent % 40 == 0) begin
      no_gaps = ($urandom_range(0, 2) == 0);
    end
    gap = no_gaps ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.op           <= op;
    in_ch.time_ms      <= stamp;
    in_ch.button_level <= level;
    in_ch.serial_byte  <= chr;
    in_ch.pot_value    <= pot;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  // Drop valid and wait until every predicted result word has come back.
  task automatic quiesce();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);  // leave margin before any config write
  endtask

  // Config writes keep valid high across a sequence; caller drops it after.
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic set_config(input int phase);
    logic [15:0] h;
    logic [15:0] g;
    logic [6:0]  s;
    case (phase)
      0: begin h = 16'd700;   g = 16'd50;    s = 7'd5;   end
      1: begin h = 16'd1;     g = 16'd0;     s = 7'd1;   end
      2: begin h = 16'd65535; g = 16'd65535; s = 7'd90;  end
      3: begin h = 16'd0;     g = 16'd0;     s = 7'd0;   end  // press and long press at once
      4: begin h = 16'd250;   g = 16'd20;    s = 7'd127; end
      default: begin
        h = 16'($urandom_range(1, 2000));
        g = 16'($urandom_range(0, 200));
        s = 7'($urandom_range(1, 90));
      end
    endcase
    write_reg(lpcc_pkg::REG_LONG_PRESS, h);
    write_reg(lpcc_pkg::REG_SAMPLE_IVL, g);
    write_reg(lpcc_pkg::REG_TICK_STEP, {9'($urandom), s});  // upper bits are don't-care
    cfg_ch.valid <= 1'b0;
    cur_hold = h;
    cur_gap  = g;
  endtask

  // Time step between button samples: mostly just past the sample interval,
  // sometimes inside it (dropped), sometimes a wild jump that may wrap.
  function automatic logic [31:0] step_ms(input bit toward_hold);
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return $urandom_range(0, cur_gap);
    if (r == 1) return $urandom;
    if (toward_hold) return 32'(cur_gap) + 1 + $urandom_range(0, cur_hold / 3 + 5);
    return 32'(cur_gap) + 1 + $urandom_range(0, 40);
  endfunction

  function automatic logic [9:0] pot_pick();
    int r;
    r = $urandom_range(0, 5);
    if (r == 0) return 10'd0;
    if (r == 1) return 10'd1023;
    return 10'($urandom);
  endfunction

  function automatic logic [7:0] serial_pick();
    if ($urandom_range(0, 4) < 3) begin
      return 8'($urandom_range(lpcc_pkg::CHAR_ONE - 1, lpcc_pkg::CHAR_NINE));
    end
    return 8'($urandom);
  endfunction

  task automatic button(input logic level, input bit toward_hold);
    now_ms = now_ms + step_ms(toward_hold);
    send_word(lpcc_pkg::OP_BUTTON, level, 8'($urandom), 10'($urandom), now_ms);
  endtask

  task automatic button_at(input logic level, input logic [31:0] stamp);
    now_ms = stamp;
    send_word(lpcc_pkg::OP_BUTTON, level, 8'($urandom), 10'($urandom), stamp);
  endtask

  // unused fields of non-button words carry random junk
  task automatic tick();
    send_word(lpcc_pkg::OP_TICK, 1'($urandom), 8'($urandom), 10'($urandom), $urandom);
  endtask

  task automatic pot_word();
    send_word(lpcc_pkg::OP_POT, 1'($urandom), 8'($urandom), pot_pick(), $urandom);
  endtask

  task automatic serial_word();
    send_word(lpcc_pkg::OP_SERIAL, 1'($urandom), serial_pick(), 10'($urandom), $urandom);
  endtask

  task automatic side_event();
    int r;
    r = $urandom_range(0, 2);
    if (r == 0) tick();
    else if (r == 1) pot_word();
    else serial_word();
  endtask

  task automatic noise_word();
    lpcc_pkg::op_t op;
    op = lpcc_pkg::op_t'($urandom_range(0, 3));
    if (op == lpcc_pkg::OP_BUTTON) button(1'($urandom), 1'b0);
    else send_word(op, 1'($urandom), 8'($urandom), 10'($urandom), $urandom);
  endtask

  // Full config round trip: hold into config mode, dial the pot, release,
  // press again to load the selection. Some runs are cut short on purpose.
  task automatic long_hold_cycle();
    logic [31:0] start;
    int          n;
    button(1'b1, 1'b0);
    start = now_ms;
    n = 0;
    while (now_ms - start < 32'(cur_hold) && n < 16) begin
      if ($urandom_range(0, 3) == 0) side_event();
      button(1'b1, 1'b1);
      n++;
    end
    if ($urandom_range(0, 3) == 0) button(1'b0, 1'b0);  // release early
    repeat ($urandom_range(0, 4)) pot_word();
    repeat ($urandom_range(0, 2)) tick();               // ignored while configuring
    button(1'b0, 1'b0);
    if ($urandom_range(0, 7) != 0) begin
      button(1'b1, 1'b0);                               // leaves config mode
      button(1'b0, 1'b0);
    end
  endtask

  task automatic short_press();
    button(1'b1, 1'b0);
    repeat ($urandom_range(0, 2)) button(1'b1, 1'b0);
    if ($urandom_range(0, 3) == 0) side_event();
    button(1'b0, 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // Main stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int target;
    int choice;
    bit paused;
    in_ch.valid        <= 1'b0;
    in_ch.op           <= lpcc_pkg::OP_BUTTON;
    in_ch.time_ms      <= '0;
    in_ch.button_level <= 1'b0;
    in_ch.serial_byte  <= '0;
    in_ch.pot_value    <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= lpcc_pkg::REG_LONG_PRESS;
    cfg_ch.data        <= '0;
    rst_n              <= 1'b0;
    now_ms     = '0;
    words_sent = 0;
    no_gaps    = 1'b0;
    paused     = 1'b0;
    cur_hold   = lpcc_pkg::LONG_PRESS_RST;
    cur_gap    = lpcc_pkg::SAMPLE_IVL_RST;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening under reset config: hold 700 ms, interval 50 ms, step 5.
    send_word(lpcc_pkg::OP_TICK, 1'b0, 8'h00, 10'h000, 32'h0000_0000);  // reload 30, feed
    send_word(lpcc_pkg::OP_TICK, 1'b1, 8'hFF, 10'h3FF, 32'hFFFF_FFFF);  // 30 -> 25
    send_word(lpcc_pkg::OP_SERIAL, 1'b0, lpcc_pkg::CHAR_ONE - 8'd1, 10'h000, '0);  // restart
    send_word(lpcc_pkg::OP_SERIAL, 1'b0, lpcc_pkg::CHAR_NINE, 10'h000, '0);  // reload 90
    send_word(lpcc_pkg::OP_SERIAL, 1'b0, lpcc_pkg::CHAR_ONE, 10'h000, '0);   // reload 10
    send_word(lpcc_pkg::OP_SERIAL, 1'b0, 8'hFF, 10'h000, '0);   // not a digit
    send_word(lpcc_pkg::OP_POT, 1'b0, 8'h00, 10'h3FF, '0);      // ignored outside config
    button_at(1'b1, 32'd0);            // inside interval from reset: dropped
    button_at(1'b1, 32'hFFFF_FFFF);    // press
    button_at(1'b1, 32'd700);          // 701 ms across the wrap: long press
    tick();                            // ignored in config mode
    button_at(1'b0, 32'd800);          // long release
    button_at(1'b1, 32'd900);          // leaves config before any pot: reload 0
    tick();                            // count 0 reloads 0 and still feeds
    button_at(1'b0, 32'd1000);         // short release
    button_at(1'b1, 32'd1100);
    button_at(1'b1, 32'd1800);         // long press
    send_word(lpcc_pkg::OP_POT, 1'b1, 8'hAA, 10'h000, '0);   // selection 90
    send_word(lpcc_pkg::OP_POT, 1'b0, 8'h55, 10'h3FF, '0);   // selection 10
    send_word(lpcc_pkg::OP_POT, 1'b1, 8'h00, 10'h155, '0);
    button_at(1'b1, 32'd1900);         // still held and latched: no event
    button_at(1'b0, 32'd1920);         // inside interval: dropped
    button_at(1'b0, 32'd2000);         // long release
    button_at(1'b1, 32'd2100);         // press loads the selection
    button_at(1'b0, 32'd2200);         // short release

    // Random phases, each under its own config; the block is drained first.
    for (int p = 0; p < NUM_PHASES; p++) begin
      quiesce();
      set_config(p);
      if (p == 1 || p == 4) begin
        now_ms = 32'hFFFF_F800;        // let timestamps wrap during this phase
      end
      target = words_sent + PHASE_WORDS;
      while (words_sent < target) begin
        // once, mid-run, stop offering until every result is back
        if (p == 3 && !paused && words_sent > target - PHASE_WORDS / 2) begin
          quiesce();
          paused = 1'b1;
        end
        choice = $urandom_range(0, 19);
        if (choice < 7) long_hold_cycle();
        else if (choice < 11) short_press();
        else if (choice < 15) repeat ($urandom_range(1, 8)) tick();
        else if (choice < 17) serial_word();
        else repeat ($urandom_range(1, 5)) noise_word();
      end
    end

    quiesce();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: random stalls per word, no-stall stretches, and two long
  // hold-offs while the sender keeps offering so the block backs up.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int  pause;
    int  taken;
    bit  quick;
    out_ch.ready <= 1'b0;
    taken = 0;
    quick = 1'b0;
    @(posedge clk);
    forever begin
      if (taken % 64 == 0) begin
        quick = ($urandom_range(0, 3) == 0);
      end
      pause = quick ? 0 : $urandom_range(0, 19);
      if (taken == 600 || taken == 1400) begin
        pause = LONG_HOLD;
      end
      if (pause > 0) begin
        out_ch.ready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      taken++;
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: a stuck handshake ends the run
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
